>>> rtl/core/text_mode_character_display_assert.svh
// assertion macros shared by the checker of the character display
// no dependencies; each macro wraps one clocked concurrent property
`ifndef TEXT_MODE_CHARACTER_DISPLAY_ASSERT_SVH
`define TEXT_MODE_CHARACTER_DISPLAY_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define TMCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmcd: property failed");

// next-cycle implication, disabled while reset is asserted
`define TMCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmcd: property failed");

`endif

>>> rtl/core/tmcd_pkg.sv
// shared types and constants of the text mode character display
// no dependencies; imported by the top level, the store and the checker
package tmcd_pkg;

    // default geometry
    localparam int TEXT_COLS_DEF   = 32;
    localparam int TEXT_ROWS_DEF   = 24;
    localparam int GLYPH_COUNT_DEF = 128;

    // store geometry
    localparam int CHAR_DEPTH = 768;
    localparam int FONT_DEPTH = 1024;
    localparam int CHAR_AW    = $clog2(CHAR_DEPTH);
    localparam int FONT_AW    = $clog2(FONT_DEPTH);

    // register window map
    localparam logic [11:0] CHAR_BASE = 12'h100;
    localparam logic [11:0] CHAR_END  = 12'h400;
    localparam logic [11:0] FONT_BASE = 12'hC00;
    localparam logic [11:0] IRQ_ADDR  = 12'h002;

    // pixel colours
    localparam logic [31:0] PAPER_ARGB = 32'hFFCC_CCCC;
    localparam logic [31:0] INK_ARGB   = 32'h0000_0000;

    // command codes
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_PIXEL = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BUS_RD,
        ST_PIX_CHAR,
        ST_PIX_FONT
    } state_t;

    typedef enum logic [1:0] {
        SEL_NONE,
        SEL_CHAR,
        SEL_FONT
    } bus_sel_t;

    // context of a pixel request in flight
    typedef struct packed {
        logic [2:0] x_lo;
        logic [2:0] y_lo;
        logic       in_area;
        logic       invert;
        logic       glyph_ok;
    } pix_ctx_t;

endpackage

>>> rtl/core/text_mode_character_display.sv
// top level of the text mode character display: command decode, sequencer, stores
// depends on tmcd_pkg and tmcd_ram
//
// A command is taken when start is high and busy is low. Every command gives
// one result beat on done, rdata, ink and colour for exactly one cycle; the
// receiver cannot stall it. A bus write or an unused code gives its result in
// the next cycle, and the next command may follow at once. A bus read passes
// through ST_BUS_RD, where the registered store data is taken. A pixel
// request passes through ST_PIX_CHAR and ST_PIX_FONT: the character store is
// read first and its byte forms the font store address, so the two registered
// reads run back to back. After reset busy stays high while both stores are
// cleared, one entry per cycle.
module text_mode_character_display
    import tmcd_pkg::*;
#(
    parameter int TEXT_COLS   = TEXT_COLS_DEF,
    parameter int TEXT_ROWS   = TEXT_ROWS_DEF,
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [11:0] addr,
    input  logic [7:0]  wdata,
    input  logic [7:0]  pix_x,
    input  logic [7:0]  pix_y,
    output logic        done,
    output logic [7:0]  rdata,
    output logic        ink,
    output logic [31:0] colour
);

    state_t               state_reg, state_next;
    bus_sel_t             sel_reg, sel_next;
    pix_ctx_t             ctx_reg, ctx_next;
    logic [FONT_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                 irq_enable_reg, irq_enable_next;
    logic                 done_reg, done_next;
    logic [7:0]           rdata_reg, rdata_next;
    logic                 ink_reg, ink_next;
    logic [31:0]          colour_reg, colour_next;

    logic                 char_we, font_we;
    logic [CHAR_AW-1:0]   char_waddr, char_raddr;
    logic [FONT_AW-1:0]   font_waddr, font_raddr;
    logic [7:0]           char_wdata, font_wdata;
    logic [7:0]           char_rdata, font_rdata;

    logic                 is_ctrl, is_char, is_font;
    logic [11:0]          char_off;
    logic [CHAR_AW-1:0]   char_idx;
    logic [4:0]           cell_col, cell_row;
    logic                 in_area;
    logic [CHAR_AW-1:0]   cell_idx;
    logic [7:0]           line;

    // window decode
    assign is_ctrl  = (addr < CHAR_BASE);
    assign is_char  = (addr >= CHAR_BASE) && (addr < CHAR_END);
    assign is_font  = (addr >= FONT_BASE);
    assign char_off = addr - CHAR_BASE;
    assign char_idx = char_off[CHAR_AW-1:0];

    // character cell of the requested pixel
    assign cell_col = pix_x[7:3];
    assign cell_row = pix_y[7:3];
    assign in_area  = ({1'b0, cell_col} < 6'(TEXT_COLS)) && ({1'b0, cell_row} < 6'(TEXT_ROWS));
    assign cell_idx = CHAR_AW'(cell_row) * CHAR_AW'(TEXT_COLS) + CHAR_AW'(cell_col);

    assign busy = (state_reg != ST_IDLE);

    // stores
    tmcd_ram #(
        .WIDTH (8),
        .DEPTH (CHAR_DEPTH)
    ) u_char_ram (
        .clk   (clk),
        .we    (char_we),
        .waddr (char_waddr),
        .wdata (char_wdata),
        .raddr (char_raddr),
        .rdata (char_rdata)
    );

    tmcd_ram #(
        .WIDTH (8),
        .DEPTH (FONT_DEPTH)
    ) u_font_ram (
        .clk   (clk),
        .we    (font_we),
        .waddr (font_waddr),
        .wdata (font_wdata),
        .raddr (font_raddr),
        .rdata (font_rdata)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            sel_reg        <= SEL_NONE;
            clr_cnt_reg    <= '0;
            irq_enable_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sel_reg        <= sel_next;
            clr_cnt_reg    <= clr_cnt_next;
            irq_enable_reg <= irq_enable_next;
            done_reg       <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ctx_reg    <= ctx_next;
        rdata_reg  <= rdata_next;
        ink_reg    <= ink_next;
        colour_reg <= colour_next;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        sel_next        = sel_reg;
        ctx_next        = ctx_reg;
        clr_cnt_next    = clr_cnt_reg;
        irq_enable_next = irq_enable_reg;
        done_next       = 1'b0;
        rdata_next      = 8'h00;
        ink_next        = 1'b0;
        colour_next     = 32'h0;
        char_we         = 1'b0;
        char_waddr      = char_idx;
        char_wdata      = wdata;
        char_raddr      = char_idx;
        font_we         = 1'b0;
        font_waddr      = addr[FONT_AW-1:0];
        font_wdata      = wdata;
        font_raddr      = addr[FONT_AW-1:0];
        line            = 8'h00;

        case (state_reg)
            ST_CLEAR:
            begin
                // sweep both stores to zero
                char_we      = ({1'b0, clr_cnt_reg} < (FONT_AW + 1)'(CHAR_DEPTH));
                char_waddr   = clr_cnt_reg[CHAR_AW-1:0];
                char_wdata   = 8'h00;
                font_we      = 1'b1;
                font_waddr   = clr_cnt_reg;
                font_wdata   = 8'h00;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == FONT_AW'(FONT_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    case (func)
                        FUNC_WRITE:
                        begin
                            char_we   = is_char;
                            font_we   = is_font;
                            done_next = 1'b1;
                            if (is_ctrl && (addr == IRQ_ADDR))
                            begin
                                irq_enable_next = wdata[0];
                            end
                        end
                        FUNC_READ:
                        begin
                            if (is_char)
                            begin
                                sel_next = SEL_CHAR;
                            end
                            else if (is_font)
                            begin
                                sel_next = SEL_FONT;
                            end
                            else
                            begin
                                sel_next = SEL_NONE;
                            end
                            state_next = ST_BUS_RD;
                        end
                        FUNC_PIXEL:
                        begin
                            char_raddr       = cell_idx;
                            ctx_next.x_lo    = pix_x[2:0];
                            ctx_next.y_lo    = pix_y[2:0];
                            ctx_next.in_area = in_area;
                            state_next       = ST_PIX_CHAR;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_BUS_RD:
            begin
                // store data is valid now
                case (sel_reg)
                    SEL_CHAR: rdata_next = char_rdata;
                    SEL_FONT: rdata_next = font_rdata;
                    default:  rdata_next = 8'h00;
                endcase
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_PIX_CHAR:
            begin
                // glyph row address from the character byte
                font_raddr        = FONT_AW'({char_rdata[6:0], ctx_reg.y_lo});
                ctx_next.invert   = char_rdata[7];
                ctx_next.glyph_ok = ({1'b0, char_rdata[6:0]} < 8'(GLYPH_COUNT));
                state_next        = ST_PIX_FONT;
            end

            ST_PIX_FONT:
            begin
                // pick the pixel bit, msb leftmost
                line = ctx_reg.glyph_ok ? font_rdata : 8'h00;
                if (ctx_reg.invert)
                begin
                    line = ~line;
                end
                ink_next    = ctx_reg.in_area && line[~ctx_reg.x_lo];
                colour_next = ink_next ? INK_ARGB : PAPER_ARGB;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done   = done_reg;
    assign rdata  = rdata_reg;
    assign ink    = ink_reg;
    assign colour = colour_reg;

endmodule

>>> rtl/core/tmcd_ram.sv
// single-port-write, single-port-read synchronous byte store
// depends on tmcd_pkg for the default depth; the caller's parameters set the size
module tmcd_ram
    import tmcd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = FONT_DEPTH
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/tmcd_checker.sv
// port-level checker of the text mode character display, bound to the top level
// depends on tmcd_pkg and text_mode_character_display_assert.svh
`include "text_mode_character_display_assert.svh"

module tmcd_checker
    import tmcd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  func,
    input logic        done,
    input logic [7:0]  rdata,
    input logic        ink,
    input logic [31:0] colour
);

    logic accept;

    assign accept = start && !busy;

    // writes and unused codes answer in the next cycle
    `TMCD_ASSERT_NXT(a_write_beat, clk, rst_n, accept && (func != FUNC_READ) && (func != FUNC_PIXEL), done)

    // a pixel request walks both stores before its beat
    `TMCD_ASSERT_NXT(a_pixel_seq, clk, rst_n, accept && (func == FUNC_PIXEL), busy ##1 busy ##1 (done && !busy))

    // a result beat always ends the command, so the block is free again
    `TMCD_ASSERT_IMP(a_done_free, clk, rst_n, done, !busy && $past(busy || start))

    // ink beats carry the ink colour and no bus data
    `TMCD_ASSERT_IMP(a_ink_colour, clk, rst_n, done && ink, (colour == INK_ARGB) && (rdata == 8'h00))

endmodule

bind text_mode_character_display tmcd_checker u_tmcd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .func   (func),
    .done   (done),
    .rdata  (rdata),
    .ink    (ink),
    .colour (colour)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench of the text mode character display: directed and random command beats
// depends on tmcd_pkg and the text_mode_character_display top level
module tb_top;
    import tmcd_pkg::*;

    localparam logic [1:0] FUNC_SPARE   = 2'd3;
    localparam int         RUN_LIMIT    = 60000;
    localparam int         RANDOM_BEATS = 550;
    localparam int         LOAD_BEATS   = 150;
    localparam int         TAIL_CYCLES  = 8;

    // one result beat as the display should give it
    typedef struct packed {
        logic [7:0]  rdata;
        logic        ink;
        logic [31:0] colour;
    } disp_result_t;

    // shadow copy of both stores, works out each result beat in command order
    class display_mirror;
        logic [7:0]   char_mem [CHAR_DEPTH];
        logic [7:0]   font_mem [FONT_DEPTH];
        logic         irq_en;
        disp_result_t pending_beats [$];
        int           errors;

        function new();
            foreach (char_mem[i]) char_mem[i] = 8'h00;
            foreach (font_mem[i]) font_mem[i] = 8'h00;
            irq_en = 1'b0;
            errors = 0;
        endfunction

        // control page and the gap read as zero
        function logic [7:0] read_byte(logic [11:0] a);
            if (a < CHAR_BASE)
                return 8'h00;
            if (a < CHAR_END)
                return char_mem[a - CHAR_BASE];
            if (a >= FONT_BASE)
                return font_mem[a - FONT_BASE];
            return 8'h00;
        endfunction

        // cell lookup, glyph row fetch, inversion on bit 7, msb leftmost
        function logic pixel_ink(logic [7:0] x, logic [7:0] y);
            int         cell_pos;
            logic [7:0] ch;
            logic [7:0] line;
            if ((x >> 3) >= TEXT_COLS_DEF || (y >> 3) >= TEXT_ROWS_DEF)
                return 1'b0;
            cell_pos = int'(y >> 3) * TEXT_COLS_DEF + int'(x >> 3);
            ch = char_mem[cell_pos];
            line = 8'h00;
            if (int'(ch[6:0]) < GLYPH_COUNT_DEF)
                line = font_mem[{ch[6:0], y[2:0]}];
            if (ch[7])
                line = ~line;
            return line[3'd7 - x[2:0]];
        endfunction

        function void note_command(logic [1:0] f, logic [11:0] a, logic [7:0] w,
                                   logic [7:0] x, logic [7:0] y);
            disp_result_t r;
            r = '0;
            case (f)
                FUNC_WRITE:
                begin
                    if (a == IRQ_ADDR)
                        irq_en = w[0];
                    else if (a >= CHAR_BASE && a < CHAR_END)
                        char_mem[a - CHAR_BASE] = w;
                    else if (a >= FONT_BASE)
                        font_mem[a - FONT_BASE] = w;
                end
                FUNC_READ:
                begin
                    r.rdata = read_byte(a);
                end
                FUNC_PIXEL:
                begin
                    r.ink = pixel_ink(x, y);
                    r.colour = r.ink ? INK_ARGB : PAPER_ARGB;
                end
                default:
                begin
                end
            endcase
            pending_beats.push_back(r);
        endfunction

        function void check_beat(logic [7:0] rd, logic ik, logic [31:0] col);
            disp_result_t e;
            if (pending_beats.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual rdata %h ink %b colour %h",
                         $time, rd, ik, col);
                errors++;
                return;
            end
            e = pending_beats.pop_front();
            if (rd !== e.rdata)
            begin
                $display("%0t: rdata expected %h actual %h", $time, e.rdata, rd);
                errors++;
            end
            if (ik !== e.ink)
            begin
                $display("%0t: ink expected %b actual %b", $time, e.ink, ik);
                errors++;
            end
            if (col !== e.colour)
            begin
                $display("%0t: colour expected %h actual %h", $time, e.colour, col);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  func;
    logic [11:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  pix_x;
    logic [7:0]  pix_y;
    logic        done;
    logic [7:0]  rdata;
    logic        ink;
    logic [31:0] colour;

    display_mirror mirror;
    int            burst_left;
    int            cycle_count = 0;

    text_mode_character_display dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .func   (func),
        .addr   (addr),
        .wdata  (wdata),
        .pix_x  (pix_x),
        .pix_y  (pix_y),
        .done   (done),
        .rdata  (rdata),
        .ink    (ink),
        .colour (colour)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("%0t: run limit reached", $time);
            $display("== FAIL ==");
            $finish;
        end
    end

    // note every accepted command beat, check every result beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                mirror.note_command(func, addr, wdata, pix_x, pix_y);
            if (done)
                mirror.check_beat(rdata, ink, colour);
        end
    end

    // one command beat, then a random gap once the current burst runs out
    task automatic send_cmd(logic [1:0] f, logic [11:0] a, logic [7:0] w,
                            logic [7:0] x, logic [7:0] y);
        int gap;
        start <= 1'b1;
        func  <= f;
        addr  <= a;
        wdata <= w;
        pix_x <= x;
        pix_y <= y;
        do
            @(posedge clk);
        while (busy);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // random beat; write_pct sets how much of the traffic fills the stores
    task automatic random_beat(int write_pct);
        logic [1:0]  f;
        logic [11:0] a;
        logic [7:0]  w;
        logic [7:0]  x;
        logic [7:0]  y;
        int          pick;
        pick = $urandom_range(0, 99);
        w = 8'($urandom_range(0, 255));
        x = 8'($urandom_range(0, 255));
        a = 12'($urandom_range(0, 4095));
        case ($urandom_range(0, 9))
            0:       y = 8'($urandom_range(192, 255));
            1, 2, 3: y = 8'($urandom_range(0, 191));
            default: y = 8'($urandom_range(0, 31));
        endcase
        if (pick < write_pct)
            f = FUNC_WRITE;
        else if (pick < write_pct + 15)
            f = FUNC_READ;
        else if (pick < 96)
            f = FUNC_PIXEL;
        else
            f = FUNC_SPARE;
        // steer bus beats mostly to the stores; small glyph set, top rows so pixels meet ink
        case ($urandom_range(0, 9))
            0:
            begin
                a = $urandom_range(0, 1) ? IRQ_ADDR : 12'($urandom_range(0, 255));
            end
            1:
            begin
                a = 12'($urandom_range(12'h400, 12'hBFF));
            end
            2, 3, 4:
            begin
                a = CHAR_BASE + 12'($urandom_range(0, $urandom_range(0, 1) ? 127 : 767));
                if ($urandom_range(0, 3) != 0)
                    w[6:4] = 3'b000;
            end
            5, 6, 7:
            begin
                a = FONT_BASE + 12'($urandom_range(0, 127));
            end
            8:
            begin
                a = FONT_BASE + 12'($urandom_range(0, FONT_DEPTH - 1));
            end
            default:
            begin
            end
        endcase
        send_cmd(f, a, w, x, y);
    endtask

    initial
    begin
        mirror = new();
        rst_n = 1'b0;
        start = 1'b0;
        func  = FUNC_WRITE;
        addr  = 12'h000;
        wdata = 8'h00;
        pix_x = 8'h00;
        pix_y = 8'h00;
        burst_left = 1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // control page: interrupt enable and ignored offsets, all read as zero
        send_cmd(FUNC_WRITE, IRQ_ADDR, 8'hFF, 8'h00, 8'h00);
        send_cmd(FUNC_READ, IRQ_ADDR, 8'h00, 8'h00, 8'h00);
        send_cmd(FUNC_WRITE, IRQ_ADDR, 8'h00, 8'h00, 8'h00);
        send_cmd(FUNC_WRITE, 12'h001, 8'hFF, 8'h00, 8'h00);
        send_cmd(FUNC_READ, 12'h000, 8'h00, 8'h00, 8'h00);
        // store edges and the gap
        send_cmd(FUNC_WRITE, CHAR_BASE, 8'h41, 8'h00, 8'h00);
        send_cmd(FUNC_WRITE, CHAR_END - 12'd1, 8'hC1, 8'h00, 8'h00);
        send_cmd(FUNC_WRITE, FONT_BASE + 12'h208, 8'h81, 8'h00, 8'h00);
        send_cmd(FUNC_WRITE, 12'hFFF, 8'h5A, 8'h00, 8'h00);
        send_cmd(FUNC_WRITE, FONT_BASE, 8'hAA, 8'h00, 8'h00);
        send_cmd(FUNC_WRITE, 12'h800, 8'h55, 8'h00, 8'h00);
        send_cmd(FUNC_READ, CHAR_BASE, 8'h00, 8'h00, 8'h00);
        send_cmd(FUNC_READ, CHAR_END - 12'd1, 8'h00, 8'h00, 8'h00);
        send_cmd(FUNC_READ, FONT_BASE, 8'h00, 8'h00, 8'h00);
        send_cmd(FUNC_READ, 12'hFFF, 8'h00, 8'h00, 8'h00);
        send_cmd(FUNC_READ, 12'h800, 8'h00, 8'h00, 8'h00);
        send_cmd(FUNC_READ, 12'hBFF, 8'h00, 8'h00, 8'h00);
        send_cmd(FUNC_READ, 12'h0FF, 8'h00, 8'h00, 8'h00);
        // pixels: glyph edges, inverted cell, plain cell, outside the text area
        send_cmd(FUNC_PIXEL, 12'h000, 8'h00, 8'd0, 8'd0);
        send_cmd(FUNC_PIXEL, 12'h000, 8'h00, 8'd3, 8'd0);
        send_cmd(FUNC_PIXEL, 12'h000, 8'h00, 8'd7, 8'd0);
        send_cmd(FUNC_PIXEL, 12'h000, 8'h00, 8'd255, 8'd191);
        send_cmd(FUNC_PIXEL, 12'h000, 8'h00, 8'd8, 8'd0);
        send_cmd(FUNC_PIXEL, 12'h000, 8'h00, 8'd0, 8'd192);
        send_cmd(FUNC_PIXEL, 12'h000, 8'h00, 8'd255, 8'd255);
        // unused code with every field at its top
        send_cmd(FUNC_SPARE, 12'hFFF, 8'hFF, 8'hFF, 8'hFF);

        // fill the stores first, then mixed traffic
        repeat (LOAD_BEATS) random_beat(70);
        repeat (RANDOM_BEATS - LOAD_BEATS) random_beat(30);
        start <= 1'b0;

        // drain, then let the last command settle
        while (mirror.pending_beats.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mirror.pending_beats.size() != 0)
            $display("%0t: %0d result beats never arrived", $time, mirror.pending_beats.size());
        if (mirror.errors == 0 && mirror.pending_beats.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
